>>> rtl/core/gle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gle_pkg;

  // field widths of the command and result transfers
  localparam int FUNC_W = 3;
  localparam int TYPE_W = 3;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // command codes
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SIM  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ALL  = 3'd4;

  // gate codes
  localparam logic [TYPE_W-1:0] G_AND  = 3'd0;
  localparam logic [TYPE_W-1:0] G_OR   = 3'd1;
  localparam logic [TYPE_W-1:0] G_NAND = 3'd2;
  localparam logic [TYPE_W-1:0] G_NOR  = 3'd3;
  localparam logic [TYPE_W-1:0] G_XOR  = 3'd4;
  localparam logic [TYPE_W-1:0] G_XNOR = 3'd5;
  localparam logic [TYPE_W-1:0] G_NOT  = 3'd6;

  // one gate table entry, 21 bits
  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  in1;
    logic [IDX_W-1:0]  in2;
    logic [IDX_W-1:0]  outn;
  } gate_entry_t;

  // output of one gate for input values a and b
  function automatic logic eval_gate(input logic [TYPE_W-1:0] kind, input logic a,
                                     input logic b);
    logic r;
    case (kind)
      G_AND:   r = a & b;
      G_OR:    r = a | b;
      G_NAND:  r = ~(a & b);
      G_NOR:   r = ~(a | b);
      G_XOR:   r = a ^ b;
      G_XNOR:  r = ~(a ^ b);
      default: r = ~a;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gle_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gle_cmd_if import gle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TYPE_W-1:0] gate_type;
  logic [IDX_W-1:0]  src_a;
  logic [IDX_W-1:0]  src_b;
  logic [IDX_W-1:0]  dest;
  logic              set_value;

  modport source (output valid, func, gate_type, src_a, src_b, dest, set_value,
                  input ready);
  modport sink (input valid, func, gate_type, src_a, src_b, dest, set_value,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/gle_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gle_res_if import gle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] node_index;
  logic             node_level;
  logic             last;

  modport source (output valid, node_index, node_level, last, input ready);
  modport sink (input valid, node_index, node_level, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gate_list_logic_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// add gate, set node and simulate with nothing pending leave the block idle and ready
// simulate, per pending gate: gate table read, node reads (S_SIM_OPS), evaluate and write
// (S_SIM_EVAL); read node passes through the node memory read register, then the output register
// read all gives one result a cycle, in node order, while the receiver does not stall
// synchronous reset clears counters, control and the node valid bits at once; no clearing pass
module gate_list_logic_evaluator import gle_pkg::*; #(
  parameter int NODES = 64,
  parameter int GATES = 256
) (
  input  wire        clk,
  input  wire        rst,
  gle_cmd_if.sink    cmd,
  gle_res_if.source  res
);

  localparam int NIW = $clog2(NODES);
  localparam int CW  = $clog2(GATES + 1);
  localparam int GIW = (GATES > 1) ? $clog2(GATES) : 1;
  localparam logic [CNT_W-1:0] NODE_LIM = CNT_W'(NODES);
  localparam logic [CW-1:0]    GATE_LIM = CW'(GATES);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SIM_OPS  = 3'd1;
  localparam logic [2:0] S_SIM_EVAL = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_ALL      = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CW-1:0]    gate_count;
  logic [CW-1:0]    sim_pointer;
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] node_count_next;

  // memories and their registered read data
  logic        node_mem [NODES];
  logic        node_ok  [NODES];
  gate_entry_t gate_mem [GATES];
  logic        rd_a;
  logic        rd_b;
  logic        ok_a;
  logic        ok_b;
  gate_entry_t gate_rd;

  logic [NIW-1:0] addr_a;
  logic [NIW-1:0] addr_b;
  logic           node_we;
  logic [NIW-1:0] node_waddr;
  logic           node_wdata;
  logic           gate_we;
  gate_entry_t    gate_new;
  logic [GIW-1:0] gate_raddr;

  // read scan and output register
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] scan_inc;
  logic             read_oob;
  logic             out_valid;
  logic [IDX_W-1:0] out_index;
  logic             out_value;
  logic             out_last;
  logic             out_free;
  logic             out_load;
  logic             all_last;

  logic             accept;
  logic             add_ok;
  logic             set_ok;
  logic [IDX_W-1:0] eff_b;
  logic [IDX_W-1:0] max_ab;
  logic [IDX_W-1:0] max_abd;
  logic [CNT_W-1:0] touch_add;
  logic [CNT_W-1:0] touch_set;
  logic [CW-1:0]    sim_inc;
  logic             val_a;
  logic             val_b;

  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !out_valid || res.ready;
  assign scan_inc = scan_idx + IDX_W'(1);
  assign all_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == node_count);
  assign sim_inc  = sim_pointer + CW'(1);
  assign val_a    = ok_a & rd_a;
  assign val_b    = ok_b & rd_b;

  // command checks
  assign eff_b  = (cmd.gate_type == G_NOT) ? cmd.src_a : cmd.src_b;
  assign add_ok = (cmd.gate_type <= G_NOT) && (gate_count < GATE_LIM)
                  && (CNT_W'(cmd.src_a) < NODE_LIM) && (CNT_W'(cmd.dest) < NODE_LIM)
                  && (CNT_W'(eff_b) < NODE_LIM);
  assign set_ok = (CNT_W'(cmd.src_a) < NODE_LIM);

  // highest node an add or set refers to
  assign max_ab    = (cmd.src_a > eff_b) ? cmd.src_a : eff_b;
  assign max_abd   = (max_ab > cmd.dest) ? max_ab : cmd.dest;
  assign touch_add = CNT_W'(max_abd) + CNT_W'(1);
  assign touch_set = CNT_W'(cmd.src_a) + CNT_W'(1);

  always_comb begin
    node_count_next = node_count;
    if (accept && cmd.func == FN_ADD && add_ok && touch_add > node_count) begin
      node_count_next = touch_add;
    end else if (accept && cmd.func == FN_SET && set_ok && touch_set > node_count) begin
      node_count_next = touch_set;
    end
  end

  // output register loads only in the read states
  always_comb begin
    out_load = 1'b0;
    if (state == S_READ || state == S_ALL) begin
      out_load = out_free;
    end
  end

  // gate table ports
  assign gate_we = accept && (cmd.func == FN_ADD) && add_ok;
  always_comb begin
    gate_new.kind = cmd.gate_type;
    gate_new.in1  = cmd.src_a;
    gate_new.in2  = eff_b;
    gate_new.outn = cmd.dest;
  end
  assign gate_raddr = (state == S_SIM_EVAL) ? sim_inc[GIW-1:0] : sim_pointer[GIW-1:0];

  // node memory read addresses
  always_comb begin
    addr_a = scan_idx[NIW-1:0];
    addr_b = gate_rd.in2[NIW-1:0];
    unique case (state)
      S_IDLE: begin
        addr_a = (cmd.func == FN_ALL) ? '0 : cmd.src_a[NIW-1:0];
      end
      S_SIM_OPS: begin
        addr_a = gate_rd.in1[NIW-1:0];
      end
      S_READ: begin
        addr_a = scan_idx[NIW-1:0];
      end
      S_ALL: begin
        addr_a = out_load ? scan_inc[NIW-1:0] : scan_idx[NIW-1:0];
      end
      default: begin
        addr_a = scan_idx[NIW-1:0];
      end
    endcase
  end

  // node memory write: set command or gate result
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cmd.src_a[NIW-1:0];
    node_wdata = cmd.set_value;
    if (state == S_SIM_EVAL) begin
      node_we    = 1'b1;
      node_waddr = gate_rd.outn[NIW-1:0];
      node_wdata = eval_gate(gate_rd.kind, val_a, val_b);
    end else if (accept && cmd.func == FN_SET && set_ok) begin
      node_we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FN_SIM:  state_next = (sim_pointer < gate_count) ? S_SIM_OPS : S_IDLE;
            FN_READ: state_next = S_READ;
            FN_ALL:  state_next = (node_count != '0) ? S_ALL : S_IDLE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SIM_OPS: begin
        state_next = S_SIM_EVAL;
      end
      S_SIM_EVAL: begin
        state_next = (sim_inc < gate_count) ? S_SIM_OPS : S_IDLE;
      end
      S_READ: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      S_ALL: begin
        if (out_load && all_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // node value memory
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    rd_a <= node_mem[addr_a];
    rd_b <= node_mem[addr_b];
    ok_a <= node_ok[addr_a];
    ok_b <= node_ok[addr_b];
  end

  // node written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        node_ok[i] <= 1'b0;
      end
    end else if (node_we) begin
      node_ok[node_waddr] <= 1'b1;
    end
  end

  // gate table memory
  always_ff @(posedge clk) begin
    if (gate_we) begin
      gate_mem[gate_count[GIW-1:0]] <= gate_new;
    end
    gate_rd <= gate_mem[gate_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      gate_count  <= '0;
      sim_pointer <= '0;
      node_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      node_count <= node_count_next;
      if (gate_we) begin
        gate_count <= gate_count + CW'(1);
      end
      if (state == S_SIM_EVAL) begin
        sim_pointer <= sim_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan index and result payload
  always_ff @(posedge clk) begin
    if (accept && cmd.func == FN_READ) begin
      scan_idx <= cmd.src_a;
      read_oob <= !set_ok;
    end else if (accept && cmd.func == FN_ALL) begin
      scan_idx <= '0;
      read_oob <= 1'b0;
    end else if (state == S_ALL && out_load) begin
      scan_idx <= scan_inc;
    end
    if (out_load) begin
      out_index <= scan_idx;
      out_value <= read_oob ? 1'b0 : val_a;
      out_last  <= (state == S_READ) ? 1'b1 : all_last;
    end
  end

  assign res.valid      = out_valid;
  assign res.node_index = out_index;
  assign res.node_level = out_value;
  assign res.last       = out_last;

`ifndef NO_ASSERTIONS
  // simulate never runs past the gates that were added
  a_sim_bound: assert property (@(posedge clk) disable iff (rst)
    sim_pointer <= gate_count)
    else $error("sim pointer beyond gate count");

  // gate count never exceeds the table
  a_gate_bound: assert property (@(posedge clk) disable iff (rst)
    gate_count <= GATE_LIM)
    else $error("gate count beyond table size");

  // node count stays within the node memory
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= NODE_LIM)
    else $error("node count beyond node memory");

  // each evaluation step retires exactly one gate
  a_sim_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIM_EVAL) |=> (sim_pointer == $past(sim_pointer) + CW'(1)))
    else $error("simulate step did not advance the pointer");

  // read all ends on the transfer loaded with last
  a_all_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALL && out_load && all_last) |=> (state == S_IDLE && out_valid && out_last))
    else $error("read all did not finish on its last node");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gle_pkg::*;

  localparam int NODES        = 64;
  localparam int MAX_GATES    = 256;
  localparam int RANDOM_ITEMS = 230;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_CAP   = 60;

  // codes the block must ignore
  localparam logic [TYPE_W-1:0] G_UNUSED   = 3'd7;
  localparam int                FN_UNKNOWN = int'(FN_ALL) + 1;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [TYPE_W-1:0] gate_type;
    logic [IDX_W-1:0]  src_a;
    logic [IDX_W-1:0]  src_b;
    logic [IDX_W-1:0]  dest;
    logic              set_value;
  } command_t;

  typedef struct packed {
    logic [IDX_W-1:0] node_index;
    logic             node_level;
    logic             last;
  } node_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic res_ready = 1'b0;

  gle_cmd_if cmd_ch ();
  gle_res_if res_ch ();

  assign res_ch.ready = res_ready;

  gate_list_logic_evaluator #(
    .NODES(NODES),
    .GATES(MAX_GATES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // shadow netlist state
  logic          node_mem [NODES];
  int unsigned   nodes_seen;
  gate_entry_t   netlist[$];
  int unsigned   evaluated;
  node_report_t  expected_reports[$];

  int unsigned   mismatches;
  int unsigned   items_sent;
  int unsigned   burst_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short when the block goes badly wrong
    if (mismatches <= REPORT_CAP) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic void mark_node(input logic [IDX_W-1:0] idx);
    if (int'(idx) + 1 > nodes_seen) nodes_seen = int'(idx) + 1;
  endfunction

  // append one report at the tail of the expected queue
  function automatic void queue_report(input node_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic logic gate_output(input gate_entry_t g);
    logic a, b;
    a = node_mem[g.in1];
    b = node_mem[g.in2];
    case (g.kind)
      G_AND:   return a & b;
      G_OR:    return a | b;
      G_NAND:  return !(a & b);
      G_NOR:   return !(a | b);
      G_XOR:   return a ^ b;
      G_XNOR:  return !(a ^ b);
      default: return !a;
    endcase
  endfunction

  // apply one accepted command to the shadow state, queue its node reports
  function automatic void predict_command(input command_t c);
    gate_entry_t g;
    case (c.func)
      FN_ADD: begin
        if (c.gate_type <= G_NOT && netlist.size() < MAX_GATES) begin
          g.kind = c.gate_type;
          g.in1  = c.src_a;
          g.in2  = (c.gate_type == G_NOT) ? c.src_a : c.src_b;
          g.outn = c.dest;
          mark_node(g.in1);
          mark_node(g.in2);
          mark_node(g.outn);
          netlist.insert(netlist.size(), g);
        end
      end
      FN_SET: begin
        mark_node(c.src_a);
        node_mem[c.src_a] = c.set_value;
      end
      FN_SIM: begin
        // later gates see values written by earlier ones
        while (evaluated < netlist.size()) begin
          node_mem[netlist[evaluated].outn] = gate_output(netlist[evaluated]);
          evaluated++;
        end
      end
      FN_READ: queue_report('{c.src_a, node_mem[c.src_a], 1'b1});
      FN_ALL: begin
        for (int i = 0; i < nodes_seen; i++)
          queue_report('{IDX_W'(i), node_mem[i], (i + 1 == nodes_seen)});
      end
      default: ;
    endcase
  endfunction

  function automatic command_t make_command(input logic [FUNC_W-1:0] f,
                                            input logic [TYPE_W-1:0] t,
                                            input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b,
                                            input logic [IDX_W-1:0] d,
                                            input logic v);
    command_t c;
    c.func      = f;
    c.gate_type = t;
    c.src_a     = a;
    c.src_b     = b;
    c.dest      = d;
    c.set_value = v;
    return c;
  endfunction

  function automatic command_t any_command();
    command_t c;
    c.func      = FUNC_W'($urandom);
    c.gate_type = TYPE_W'($urandom);
    c.src_a     = IDX_W'($urandom);
    c.src_b     = IDX_W'($urandom);
    c.dest      = IDX_W'($urandom);
    c.set_value = 1'($urandom);
    return c;
  endfunction

  // mostly low indices so that gates feed each other
  function automatic logic [IDX_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, NODES - 1));
    return IDX_W'($urandom_range(0, 23));
  endfunction

  // a command of the given kind with random content, now and then pure noise
  function automatic command_t round_item(input logic [FUNC_W-1:0] f);
    command_t c;
    c = any_command();
    if ($urandom_range(0, 9) == 0) return c;
    c.func  = f;
    c.src_a = pick_node();
    c.src_b = pick_node();
    c.dest  = pick_node();
    return c;
  endfunction

  // one command transfer; the sender runs in bursts with a random gap, sometimes none, between them
  task automatic send_command(input command_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.func      <= c.func;
    cmd_ch.gate_type <= c.gate_type;
    cmd_ch.src_a     <= c.src_a;
    cmd_ch.src_b     <= c.src_b;
    cmd_ch.dest      <= c.dest;
    cmd_ch.set_value <= c.set_value;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_command(c);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: each random window is either calm or has random stalls
  int unsigned window_left = 0;
  int unsigned stall_left  = 0;
  bit          calm        = 1'b1;

  always @(posedge clk) begin
    if (window_left == 0) begin
      window_left = $urandom_range(20, 120);
      calm        = ($urandom_range(0, 2) == 0);
    end else begin
      window_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 7);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest queued report
  always @(posedge clk) begin : result_check
    node_report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result node %0d value %0d last %0d",
                                  res_ch.node_index, res_ch.node_level, res_ch.last));
      end else begin
        want = expected_reports.pop_front();
        if (res_ch.node_index !== want.node_index)
          report_mismatch($sformatf("node_index %0d, wanted %0d",
                                    res_ch.node_index, want.node_index));
        if (res_ch.node_level !== want.node_level)
          report_mismatch($sformatf("node %0d value %0d, wanted %0d",
                                    want.node_index, res_ch.node_level, want.node_level));
        if (res_ch.last !== want.last)
          report_mismatch($sformatf("node %0d last %0d, wanted %0d",
                                    want.node_index, res_ch.last, want.last));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // empty netlist: read all gives nothing, unreferenced nodes read as zero
  task automatic test_empty_netlist;
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_READ, G_AND, 6'd63, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ADD, G_UNUSED, 6'd10, 6'd11, 6'd12, 1'b1));
    send_command(make_command(FN_SIM, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_READ, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
  endtask

  // every gate kind, chained gates, ignored codes and the top node
  task automatic test_gate_kinds;
    send_command(make_command(FN_SET, G_AND, 6'd0, 6'd0, 6'd0, 1'b1));
    send_command(make_command(FN_SET, G_AND, 6'd1, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ADD, G_AND, 6'd0, 6'd1, 6'd2, 1'b0));
    send_command(make_command(FN_ADD, G_OR, 6'd0, 6'd1, 6'd3, 1'b0));
    send_command(make_command(FN_ADD, G_NAND, 6'd0, 6'd1, 6'd4, 1'b0));
    send_command(make_command(FN_ADD, G_NOR, 6'd2, 6'd3, 6'd5, 1'b0));
    send_command(make_command(FN_ADD, G_XOR, 6'd0, 6'd1, 6'd6, 1'b0));
    send_command(make_command(FN_ADD, G_XNOR, 6'd6, 6'd4, 6'd7, 1'b0));
    // not ignores its second input, which must not count as referenced
    send_command(make_command(FN_ADD, G_NOT, 6'd7, 6'd63, 6'd8, 1'b0));
    send_command(make_command(FN_ADD, G_UNUSED, 6'd0, 6'd1, 6'd40, 1'b0));
    send_command(make_command(FN_SIM, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_READ, G_AND, 6'd40, 6'd0, 6'd0, 1'b0));
    for (int f = FN_UNKNOWN; f < (1 << FUNC_W); f++) begin
      command_t c;
      c = any_command();
      c.func = FUNC_W'(f);
      send_command(c);
    end
    send_command(make_command(FN_SIM, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_SET, G_AND, 6'd63, 6'd0, 6'd0, 1'b1));
    send_command(make_command(FN_READ, G_AND, 6'd63, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
  endtask

  // rounds of set, add, simulate and read with random content
  task automatic test_random_netlists;
    int unsigned first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 4)) send_command(round_item(FN_SET));
      repeat ($urandom_range(1, 6)) send_command(round_item(FN_ADD));
      // sometimes leave gates pending across rounds
      if ($urandom_range(0, 3) != 0) send_command(round_item(FN_SIM));
      if ($urandom_range(0, 2) == 0) send_command(round_item(FN_ALL));
      else repeat ($urandom_range(1, 3)) send_command(round_item(FN_READ));
    end
  endtask

  // fill the gate table, then adds must be dropped
  task automatic test_full_table;
    while (netlist.size() < MAX_GATES) send_command(round_item(FN_ADD));
    send_command(make_command(FN_ADD, G_AND, 6'd1, 6'd2, 6'd3, 1'b0));
    send_command(make_command(FN_SIM, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ADD, G_NOT, 6'd5, 6'd0, 6'd6, 1'b0));
    send_command(make_command(FN_ADD, G_XOR, 6'd63, 6'd62, 6'd0, 1'b1));
    send_command(make_command(FN_SIM, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_READ, G_AND, 6'd6, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_READ, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
    send_command(make_command(FN_ALL, G_AND, 6'd0, 6'd0, 6'd0, 1'b0));
  endtask

  initial begin
    foreach (node_mem[i]) node_mem[i] = 1'b0;
    nodes_seen  = 0;
    evaluated   = 0;
    mismatches  = 0;
    items_sent  = 0;
    burst_left  = 0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.func      <= FN_SIM;
    cmd_ch.gate_type <= G_AND;
    cmd_ch.src_a     <= '0;
    cmd_ch.src_b     <= '0;
    cmd_ch.dest      <= '0;
    cmd_ch.set_value <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_netlist;
    test_gate_kinds;
    test_random_netlists;
    test_full_table;

    // drain, then give stray results time to show up
    cmd_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gle_pkg.sv
rtl/core/gle_cmd_if.sv
rtl/core/gle_res_if.sv
rtl/core/gate_list_logic_evaluator.sv
bench/tb_top.sv
